@@ hdl/ths_pkg.sv @@
// ============================================================================
// Telescope hit selector package
// Shared types, codes and constants of the telescope hit selector.
// ============================================================================
`default_nettype none

package ths_pkg;

    // Depth of the item queue between the front and the back part.
    localparam int QUEUE_DEPTH = 4;

    // Charges at or above this cap (50.0 in Q8.16) are never selected.
    localparam logic signed [23:0] CHARGE_CAP = 24'sd3276800;

    // Saturation limits of the 28-bit sums.
    localparam logic signed [27:0] SUM_MAX = 28'sh7FFFFFF;
    localparam logic signed [27:0] SUM_MIN = 28'sh8000000;

    // E hit counter saturation value.
    localparam logic [7:0] E_COUNT_MAX = 8'd255;

    // Configuration register indexes.
    localparam logic [2:0] CFG_X_THRESHOLD   = 3'd0;
    localparam logic [2:0] CFG_Y_THRESHOLD   = 3'd1;
    localparam logic [2:0] CFG_DSSD_MODE     = 3'd2;
    localparam logic [2:0] CFG_E_DET_COUNT   = 3'd3;
    localparam logic [2:0] CFG_TELESCOPE_NUM = 3'd4;

    localparam logic [3:0] E_DET_COUNT_RESET = 4'd8;

    typedef enum logic [1:0] {
        CMD_X   = 2'd0,
        CMD_Y   = 2'd1,
        CMD_E   = 2'd2,
        CMD_END = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        KIND_X   = 3'd0,
        KIND_Y   = 3'd1,
        KIND_E   = 3'd2,
        KIND_TOT = 3'd3,
        KIND_ERR = 3'd4
    } t_kind;

    typedef enum logic [2:0] {
        ST_RUN,
        ST_XREC,
        ST_YREC,
        ST_EREC,
        ST_TOT,
        ST_ERR
    } t_state;

    typedef struct packed {
        logic signed [23:0] x_threshold;
        logic signed [23:0] y_threshold;
        logic               dssd_mode;
        logic        [3:0]  e_det_count;
        logic        [7:0]  telescope_num;
    } t_cfg;

    // One classified item as it travels through the queue.
    typedef struct packed {
        t_cmd               cmd;
        logic               in_range;
        logic        [7:0]  detector_id;
        logic signed [23:0] charge;
        logic signed [23:0] timing;
    } t_item;

    typedef struct packed {
        t_kind              kind;
        logic        [7:0]  telescope_tag;
        logic        [7:0]  strip_id;
        logic signed [23:0] energy;
        logic signed [23:0] hit_time;
        logic               valid_res;
        logic signed [27:0] de_sum;
        logic signed [27:0] e_sum;
        logic signed [27:0] total_energy;
        logic               last;
    } t_rec;

endpackage

`default_nettype wire

@@ hdl/ths_front.sv @@
// ============================================================================
// Telescope hit selector front part
// Classifies incoming hits and holds them in a short queue for the back part.
// ============================================================================
`default_nettype none

module ths_front #(
    parameter int MAX_E_DETECTORS = 8,
    parameter int CNT_W           = $clog2(MAX_E_DETECTORS + 1)
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic [CNT_W-1:0]   i_limit,
    input  wire logic               i_push,
    output logic                    o_full,
    input  wire logic [1:0]         i_cmd,
    input  wire logic [7:0]         i_detector_id,
    input  wire logic signed [23:0] i_charge,
    input  wire logic signed [23:0] i_timing,
    output logic                    o_item_valid,
    output ths_pkg::t_item          o_item,
    input  wire logic               i_item_pop
);

    localparam int PTR_W = $clog2(ths_pkg::QUEUE_DEPTH);
    localparam int QCNT_W = $clog2(ths_pkg::QUEUE_DEPTH + 1);

    ths_pkg::t_item r_mem [ths_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [QCNT_W-1:0] r_count;

    ths_pkg::t_item w_item;
    logic           w_wr;
    logic           w_rd;

    // An E hit is stored only when its id is below the active detector limit.
    always_comb begin
        w_item.cmd         = ths_pkg::t_cmd'(i_cmd);
        w_item.in_range    = ({1'b0, i_detector_id} < 9'(i_limit));
        w_item.detector_id = i_detector_id;
        w_item.charge      = i_charge;
        w_item.timing      = i_timing;
    end

    assign o_full       = (r_count == QCNT_W'(ths_pkg::QUEUE_DEPTH));
    assign o_item_valid = (r_count != '0);
    assign o_item       = r_mem[r_rd_ptr];
    assign w_wr         = i_push && !o_full;
    assign w_rd         = i_item_pop && o_item_valid;

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= w_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_wr) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_rd) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (w_wr && !w_rd) begin
                r_count <= r_count + 1'b1;
            end else if (!w_wr && w_rd) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

@@ hdl/ths_back.sv @@
// ============================================================================
// Telescope hit selector back part
// Keeps the event state, selects hits and emits the records of an event.
// ============================================================================
`default_nettype none

module ths_back #(
    parameter int MAX_E_DETECTORS = 8,
    parameter int CNT_W           = $clog2(MAX_E_DETECTORS + 1)
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire ths_pkg::t_cfg    i_cfg,
    input  wire logic [CNT_W-1:0] i_limit,
    input  wire logic             i_item_valid,
    input  wire ths_pkg::t_item   i_item,
    output logic                  o_item_pop,
    output logic                  o_rec_valid,
    output ths_pkg::t_rec         o_rec,
    input  wire logic             i_rec_pop
);

    localparam int IDX_W = (MAX_E_DETECTORS > 1) ? $clog2(MAX_E_DETECTORS) : 1;

    ths_pkg::t_state r_state, n_state;
    logic [CNT_W-1:0] r_idx, n_idx;

    logic               r_x_found, r_y_found, r_any_hit;
    logic signed [23:0] r_x_charge, r_x_time, r_y_charge, r_y_time;
    logic        [7:0]  r_x_id, r_y_id;
    logic signed [23:0] r_e_charge [MAX_E_DETECTORS];
    logic signed [23:0] r_e_time   [MAX_E_DETECTORS];
    logic [MAX_E_DETECTORS-1:0] r_e_seen;
    logic signed [27:0] r_e_sum;
    logic        [7:0]  r_e_count;

    ths_pkg::t_rec r_out;
    logic          r_out_valid;

    ths_pkg::t_rec w_rec;
    logic          w_load, w_clear, w_out_free;
    logic          w_xp, w_yp;
    logic signed [24:0] w_de25;
    logic signed [27:0] w_de;
    logic signed [28:0] w_tot29, w_esum29;
    logic [IDX_W-1:0]   w_hit_idx, w_rd_idx;

    assign w_out_free = !r_out_valid || i_rec_pop;
    assign w_xp = r_x_found && (r_x_charge > i_cfg.x_threshold);
    assign w_yp = r_y_found && (r_y_charge > i_cfg.y_threshold);

    // dE from the passing layers; two 24-bit values cannot leave 28 bits.
    always_comb begin
        if (i_cfg.dssd_mode) begin
            w_de25 = w_xp ? 25'(r_x_charge) : '0;
        end else begin
            w_de25 = (w_xp ? 25'(r_x_charge) : 25'sd0) + (w_yp ? 25'(r_y_charge) : 25'sd0);
        end
        w_de = 28'(w_de25);
        w_tot29 = 29'(w_de) + 29'(r_e_sum);
        w_esum29 = 29'(r_e_sum) + 29'(i_item.charge);
    end

    assign w_hit_idx = i_item.detector_id[IDX_W-1:0];
    assign w_rd_idx  = r_idx[IDX_W-1:0];

    always_comb begin
        n_state    = r_state;
        n_idx      = r_idx;
        o_item_pop = 1'b0;
        w_load     = 1'b0;
        w_clear    = 1'b0;
        w_rec      = '0;
        w_rec.telescope_tag = i_cfg.telescope_num;
        case (r_state)
            ths_pkg::ST_RUN: begin
                if (i_item_valid) begin
                    o_item_pop = 1'b1;
                    if (i_item.cmd == ths_pkg::CMD_END) begin
                        if (!r_any_hit) begin
                            w_clear = 1'b1;
                        end else if (r_e_count > {4'b0, i_cfg.e_det_count}) begin
                            n_state = ths_pkg::ST_ERR;
                        end else begin
                            n_state = ths_pkg::ST_XREC;
                        end
                    end
                end
            end
            ths_pkg::ST_XREC: begin
                w_rec.kind = ths_pkg::KIND_X;
                if (w_xp) begin
                    w_rec.strip_id  = r_x_id;
                    w_rec.energy    = r_x_charge;
                    w_rec.hit_time  = r_x_time;
                    w_rec.valid_res = 1'b1;
                end
                if (w_out_free) begin
                    w_load  = 1'b1;
                    n_state = ths_pkg::ST_YREC;
                end
            end
            ths_pkg::ST_YREC: begin
                w_rec.kind = ths_pkg::KIND_Y;
                if (w_yp) begin
                    w_rec.strip_id  = r_y_id;
                    w_rec.energy    = r_y_charge;
                    w_rec.hit_time  = r_y_time;
                    w_rec.valid_res = 1'b1;
                end
                if (w_out_free) begin
                    w_load = 1'b1;
                    n_idx  = '0;
                    n_state = (i_limit == '0) ? ths_pkg::ST_TOT : ths_pkg::ST_EREC;
                end
            end
            ths_pkg::ST_EREC: begin
                w_rec.kind     = ths_pkg::KIND_E;
                w_rec.strip_id = 8'(r_idx);
                if (r_e_seen[w_rd_idx]) begin
                    w_rec.energy    = r_e_charge[w_rd_idx];
                    w_rec.hit_time  = r_e_time[w_rd_idx];
                    w_rec.valid_res = 1'b1;
                end
                if (w_out_free) begin
                    w_load = 1'b1;
                    n_idx  = r_idx + 1'b1;
                    if (n_idx == i_limit) begin
                        n_state = ths_pkg::ST_TOT;
                    end
                end
            end
            ths_pkg::ST_TOT: begin
                w_rec.kind  = ths_pkg::KIND_TOT;
                w_rec.de_sum = w_de;
                w_rec.e_sum  = r_e_sum;
                if (w_tot29[28] != w_tot29[27]) begin
                    w_rec.total_energy = w_tot29[28] ? ths_pkg::SUM_MIN : ths_pkg::SUM_MAX;
                end else begin
                    w_rec.total_energy = w_tot29[27:0];
                end
                w_rec.last = 1'b1;
                if (w_out_free) begin
                    w_load  = 1'b1;
                    w_clear = 1'b1;
                    n_state = ths_pkg::ST_RUN;
                end
            end
            ths_pkg::ST_ERR: begin
                w_rec.kind = ths_pkg::KIND_ERR;
                w_rec.last = 1'b1;
                if (w_out_free) begin
                    w_load  = 1'b1;
                    w_clear = 1'b1;
                    n_state = ths_pkg::ST_RUN;
                end
            end
            default: begin
                n_state = ths_pkg::ST_RUN;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ths_pkg::ST_RUN;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

    // Event flags and sums; the stored values stay, gated by their flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || w_clear) begin
            r_x_found <= 1'b0;
            r_y_found <= 1'b0;
            r_any_hit <= 1'b0;
            r_e_seen  <= '0;
            r_e_sum   <= '0;
            r_e_count <= '0;
        end else if (o_item_pop) begin
            case (i_item.cmd)
                ths_pkg::CMD_X: begin
                    r_any_hit <= 1'b1;
                    if (i_item.charge < ths_pkg::CHARGE_CAP &&
                        (!r_x_found || i_item.charge > r_x_charge)) begin
                        r_x_found <= 1'b1;
                    end
                end
                ths_pkg::CMD_Y: begin
                    r_any_hit <= 1'b1;
                    if (i_item.charge < ths_pkg::CHARGE_CAP &&
                        (!r_y_found || i_item.charge > r_y_charge)) begin
                        r_y_found <= 1'b1;
                    end
                end
                ths_pkg::CMD_E: begin
                    r_any_hit <= 1'b1;
                    if (r_e_count != ths_pkg::E_COUNT_MAX) begin
                        r_e_count <= r_e_count + 1'b1;
                    end
                    if (i_item.in_range) begin
                        r_e_seen[w_hit_idx] <= 1'b1;
                        if (w_esum29[28] != w_esum29[27]) begin
                            r_e_sum <= w_esum29[28] ? ths_pkg::SUM_MIN : ths_pkg::SUM_MAX;
                        end else begin
                            r_e_sum <= w_esum29[27:0];
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_item_pop) begin
            if (i_item.cmd == ths_pkg::CMD_X && i_item.charge < ths_pkg::CHARGE_CAP &&
                (!r_x_found || i_item.charge > r_x_charge)) begin
                r_x_charge <= i_item.charge;
                r_x_id     <= i_item.detector_id;
                r_x_time   <= i_item.timing;
            end
            if (i_item.cmd == ths_pkg::CMD_Y && i_item.charge < ths_pkg::CHARGE_CAP &&
                (!r_y_found || i_item.charge > r_y_charge)) begin
                r_y_charge <= i_item.charge;
                r_y_id     <= i_item.detector_id;
                r_y_time   <= i_item.timing;
            end
            if (i_item.cmd == ths_pkg::CMD_E && i_item.in_range) begin
                r_e_charge[w_hit_idx] <= i_item.charge;
                r_e_time[w_hit_idx]   <= i_item.timing;
            end
        end
    end

    // Output register: a new record enters as the previous one is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (i_rec_pop) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out <= w_rec;
        end
    end

    assign o_rec_valid = r_out_valid;
    assign o_rec       = r_out;

endmodule

`default_nettype wire

@@ hdl/telescope_hit_selector_top.sv @@
// ============================================================================
// Telescope hit selector
// Builds one telescope record set per event from a stream of tagged hits.
// ============================================================================
// Usage: hits enter through a queue-like port. A transfer takes place at a
// rising edge with push high and full low; cmd selects an X, Y or E hit or
// the end-of-event marker. Results leave through a second queue-like port:
// the oldest record is on the o_ fields while empty is low, and a transfer
// takes place at an edge with pop high and empty low.
// Hits are taken one per cycle while full is low and produce no records. An
// end marker after hits starts the emission of X, Y, one entry per active E
// detector and the totals record, or a single error record. The marker passes
// the item queue and the event state before the first record reaches the
// output register, then one record per cycle as long as the receiver pops.
// While records are emitted, further hits collect in a four-entry queue;
// once it fills, full stays high until the emission is done.
// A stalled receiver holds the current record and pauses the emission.
// The user writes configuration via i_cfg_we, i_cfg_index and i_cfg_data only
// while the block is idle (not enforced by the block). Reset (synchronous,
// active low) clears the event state, both queues and resets the registers.
// ============================================================================
`default_nettype none

module telescope_hit_selector_top #(
    parameter int MAX_E_DETECTORS = 8
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [2:0]         i_cfg_index,
    input  wire logic [23:0]        i_cfg_data,
    input  wire logic               push,
    output logic                    full,
    input  wire logic [1:0]         i_cmd,
    input  wire logic [7:0]         i_detector_id,
    input  wire logic signed [23:0] i_charge,
    input  wire logic signed [23:0] i_timing,
    output logic                    empty,
    input  wire logic               pop,
    output logic [2:0]              o_kind,
    output logic [7:0]              o_telescope_tag,
    output logic [7:0]              o_strip_id,
    output logic signed [23:0]      o_energy,
    output logic signed [23:0]      o_hit_time,
    output logic                    o_valid_res,
    output logic signed [27:0]      o_de_sum,
    output logic signed [27:0]      o_e_sum,
    output logic signed [27:0]      o_total_energy,
    output logic                    o_last
);

    localparam int CNT_W = $clog2(MAX_E_DETECTORS + 1);

    ths_pkg::t_cfg  r_cfg;
    logic [CNT_W-1:0] w_limit;
    logic           w_item_valid, w_item_pop, w_rec_valid;
    ths_pkg::t_item w_item;
    ths_pkg::t_rec  w_rec;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.x_threshold   <= '0;
            r_cfg.y_threshold   <= '0;
            r_cfg.dssd_mode     <= 1'b0;
            r_cfg.e_det_count   <= ths_pkg::E_DET_COUNT_RESET;
            r_cfg.telescope_num <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                ths_pkg::CFG_X_THRESHOLD:   r_cfg.x_threshold   <= i_cfg_data;
                ths_pkg::CFG_Y_THRESHOLD:   r_cfg.y_threshold   <= i_cfg_data;
                ths_pkg::CFG_DSSD_MODE:     r_cfg.dssd_mode     <= i_cfg_data[0];
                ths_pkg::CFG_E_DET_COUNT:   r_cfg.e_det_count   <= i_cfg_data[3:0];
                ths_pkg::CFG_TELESCOPE_NUM: r_cfg.telescope_num <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    // The number of E entries per event is the smaller of the configured
    // detector count and the storage depth.
    always_comb begin
        if (32'(r_cfg.e_det_count) < MAX_E_DETECTORS) begin
            w_limit = CNT_W'(r_cfg.e_det_count);
        end else begin
            w_limit = CNT_W'(MAX_E_DETECTORS);
        end
    end

    ths_front #(
        .MAX_E_DETECTORS(MAX_E_DETECTORS),
        .CNT_W(CNT_W)
    ) u_front (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_limit(w_limit),
        .i_push(push),
        .o_full(full),
        .i_cmd(i_cmd),
        .i_detector_id(i_detector_id),
        .i_charge(i_charge),
        .i_timing(i_timing),
        .o_item_valid(w_item_valid),
        .o_item(w_item),
        .i_item_pop(w_item_pop)
    );

    ths_back #(
        .MAX_E_DETECTORS(MAX_E_DETECTORS),
        .CNT_W(CNT_W)
    ) u_back (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg(r_cfg),
        .i_limit(w_limit),
        .i_item_valid(w_item_valid),
        .i_item(w_item),
        .o_item_pop(w_item_pop),
        .o_rec_valid(w_rec_valid),
        .o_rec(w_rec),
        .i_rec_pop(pop)
    );

    assign empty           = !w_rec_valid;
    assign o_kind          = w_rec.kind;
    assign o_telescope_tag = w_rec.telescope_tag;
    assign o_strip_id      = w_rec.strip_id;
    assign o_energy        = w_rec.energy;
    assign o_hit_time      = w_rec.hit_time;
    assign o_valid_res     = w_rec.valid_res;
    assign o_de_sum        = w_rec.de_sum;
    assign o_e_sum         = w_rec.e_sum;
    assign o_total_energy  = w_rec.total_energy;
    assign o_last          = w_rec.last;

endmodule

`default_nettype wire

@@ bench/tb_telescope_hit_selector_top.sv @@
`timescale 1ns / 100ps
// ============================================================================
// Telescope hit selector testbench
// Drives tagged hits and end markers into the selector under several register
// settings, predicts every emitted record with an in-bench model of the
// selection and summing rules, and compares each popped record field by
// field. Both handshake sides idle at random, and one phase holds the
// receiver off long enough to fill the block and stall its input.
// ============================================================================

module tb_telescope_hit_selector_top;

    import ths_pkg::*;

    localparam int CLK_PERIOD   = 10;
    localparam int MAX_E        = 8;
    // Time the block may still be busy after the last predicted record:
    // emission start-up, a full record set and a full item queue.
    localparam int DRAIN_CYCLES = 24;
    localparam int LIMIT_CYCLES = 3000000;

    // ------------------------------------------------------------------
    // Block ports
    // ------------------------------------------------------------------
    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [2:0]         i_cfg_index;
    logic [23:0]        i_cfg_data;
    logic               push;
    logic               full;
    logic [1:0]         i_cmd;
    logic [7:0]         i_detector_id;
    logic signed [23:0] i_charge;
    logic signed [23:0] i_timing;
    logic               empty;
    logic               pop;
    logic [2:0]         o_kind;
    logic [7:0]         o_telescope_tag;
    logic [7:0]         o_strip_id;
    logic signed [23:0] o_energy;
    logic signed [23:0] o_hit_time;
    logic               o_valid_res;
    logic signed [27:0] o_de_sum;
    logic signed [27:0] o_e_sum;
    logic signed [27:0] o_total_energy;
    logic               o_last;

    telescope_hit_selector_top #(
        .MAX_E_DETECTORS(MAX_E)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .push           (push),
        .full           (full),
        .i_cmd          (i_cmd),
        .i_detector_id  (i_detector_id),
        .i_charge       (i_charge),
        .i_timing       (i_timing),
        .empty          (empty),
        .pop            (pop),
        .o_kind         (o_kind),
        .o_telescope_tag(o_telescope_tag),
        .o_strip_id     (o_strip_id),
        .o_energy       (o_energy),
        .o_hit_time     (o_hit_time),
        .o_valid_res    (o_valid_res),
        .o_de_sum       (o_de_sum),
        .o_e_sum        (o_e_sum),
        .o_total_energy (o_total_energy),
        .o_last         (o_last)
    );

    // ------------------------------------------------------------------
    // Shadow copy of the registers, kept in step with every write.
    // ------------------------------------------------------------------
    logic signed [23:0] cfg_x_thr;
    logic signed [23:0] cfg_y_thr;
    logic               cfg_dssd;
    logic [3:0]         cfg_e_count;
    logic [7:0]         cfg_tel;

    // Event state of the predictor: best X and Y candidates, the E store
    // and the running E sum.
    logic signed [23:0] x_kept_q, x_kept_t, y_kept_q, y_kept_t;
    logic [7:0]         x_kept_id, y_kept_id;
    bit                 x_kept, y_kept, event_has_hit;
    logic signed [23:0] e_store_q [MAX_E];
    logic signed [23:0] e_store_t [MAX_E];
    bit                 e_written [MAX_E];
    logic signed [27:0] e_sum_acc;
    int                 e_hits;

    // Records predicted for accepted end markers, oldest first.
    t_rec expected_records [$];
    t_rec oldest_record;

    int error_count      = 0;
    int records_checked  = 0;
    int items_sent       = 0;
    int events_sent      = 0;
    int settings_applied = 0;

    // Handshake pacing. The receiver hold is counted down by the pop process.
    bit sender_idle_en   = 1'b1;
    bit receiver_idle_en = 1'b1;
    int consumer_hold    = 0;
    int pop_wait         = 0;

    // ------------------------------------------------------------------
    // Clock and run limit
    // ------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // A hang anywhere (lost record, stuck full) ends the run here.
    initial begin
        #(longint'(LIMIT_CYCLES) * CLK_PERIOD);
        $display("%0t: timeout, %0d records still predicted", $time,
                 expected_records.size());
        $display("FAIL telescope_hit_selector_top");
        $finish;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic logic signed [27:0] clamp28(input longint v);
        if (v > longint'(SUM_MAX)) return SUM_MAX;
        if (v < longint'(SUM_MIN)) return SUM_MIN;
        return 28'(v);
    endfunction

    // A record with every data field zero; the tag is carried in all kinds.
    function automatic t_rec empty_record(input t_kind k);
        t_rec r;
        r = '0;
        r.kind = k;
        r.telescope_tag = cfg_tel;
        return r;
    endfunction

    task automatic clear_event_state();
        x_kept_q = '0; x_kept_t = '0; x_kept_id = '0; x_kept = 1'b0;
        y_kept_q = '0; y_kept_t = '0; y_kept_id = '0; y_kept = 1'b0;
        for (int i = 0; i < MAX_E; i++) begin
            e_store_q[i] = '0;
            e_store_t[i] = '0;
            e_written[i] = 1'b0;
        end
        e_sum_acc = '0;
        e_hits = 0;
        event_has_hit = 1'b0;
    endtask

    // Works out the records that one accepted item causes and queues them.
    task automatic predict_item(input t_cmd cmd, input logic [7:0] id,
                                input logic signed [23:0] q,
                                input logic signed [23:0] t);
        int                 limit;
        bit                 x_pass, y_pass;
        longint             x_part, y_part;
        logic signed [27:0] de, tot;
        t_rec               rec;
        limit = (cfg_e_count < MAX_E) ? int'(cfg_e_count) : MAX_E;
        case (cmd)
            CMD_X, CMD_Y: begin
                // A hit at or above the cap still opens the event.
                event_has_hit = 1'b1;
                if (q < CHARGE_CAP) begin
                    if (cmd == CMD_X && (!x_kept || q > x_kept_q)) begin
                        x_kept = 1'b1; x_kept_q = q; x_kept_id = id; x_kept_t = t;
                    end else if (cmd == CMD_Y && (!y_kept || q > y_kept_q)) begin
                        y_kept = 1'b1; y_kept_q = q; y_kept_id = id; y_kept_t = t;
                    end
                end
            end
            CMD_E: begin
                event_has_hit = 1'b1;
                if (e_hits < 255) e_hits++;
                // Out-of-range detectors are counted but neither stored nor summed.
                if (id < limit) begin
                    e_store_q[id] = q;
                    e_store_t[id] = t;
                    e_written[id] = 1'b1;
                    e_sum_acc = clamp28(longint'(e_sum_acc) + longint'(q));
                end
            end
            default: begin
                if (!event_has_hit) begin
                    // An empty event produces nothing.
                end else if (e_hits > cfg_e_count) begin
                    rec = empty_record(KIND_ERR);
                    rec.last = 1'b1;
                    expected_records.push_back(rec);
                end else begin
                    x_pass = x_kept && x_kept_q > cfg_x_thr;
                    y_pass = y_kept && y_kept_q > cfg_y_thr;
                    x_part = x_pass ? longint'(x_kept_q) : 0;
                    y_part = y_pass ? longint'(y_kept_q) : 0;
                    de  = cfg_dssd ? clamp28(x_part) : clamp28(x_part + y_part);
                    tot = clamp28(longint'(de) + longint'(e_sum_acc));

                    rec = empty_record(KIND_X);
                    if (x_pass) begin
                        rec.strip_id = x_kept_id;
                        rec.energy = x_kept_q;
                        rec.hit_time = x_kept_t;
                        rec.valid_res = 1'b1;
                    end
                    expected_records.push_back(rec);

                    rec = empty_record(KIND_Y);
                    if (y_pass) begin
                        rec.strip_id = y_kept_id;
                        rec.energy = y_kept_q;
                        rec.hit_time = y_kept_t;
                        rec.valid_res = 1'b1;
                    end
                    expected_records.push_back(rec);

                    for (int i = 0; i < limit; i++) begin
                        rec = empty_record(KIND_E);
                        rec.strip_id = 8'(i);
                        rec.energy = e_store_q[i];
                        rec.hit_time = e_store_t[i];
                        rec.valid_res = e_written[i];
                        expected_records.push_back(rec);
                    end

                    rec = empty_record(KIND_TOT);
                    rec.de_sum = de;
                    rec.e_sum = e_sum_acc;
                    rec.total_energy = tot;
                    rec.last = 1'b1;
                    expected_records.push_back(rec);
                end
                clear_event_state();
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // Result side: pop pacing and the record checker
    // ------------------------------------------------------------------
    function automatic int random_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 15);
        return $urandom_range(30, 60);
    endfunction

    // Pop is raised and then dropped for a random gap that may be empty, unless a
    // long hold has been requested, which this process counts out itself.
    initial begin
        pop = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!i_rst_n) begin
                pop = 1'b0;
            end else if (consumer_hold > 0) begin
                consumer_hold--;
                pop = 1'b0;
            end else if (pop_wait > 0) begin
                pop_wait--;
                pop = 1'b0;
            end else begin
                pop = 1'b1;
                pop_wait = receiver_idle_en ? random_gap() : 0;
            end
        end
    end

    task automatic compare_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            error_count++;
        end
    endtask

    // Every record transfer is checked against the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) begin
            if (expected_records.size() == 0) begin
                $display("%0t: record of kind %0d with no prediction waiting",
                         $time, o_kind);
                error_count++;
            end else begin
                oldest_record = expected_records.pop_front();
                compare_field("kind", oldest_record.kind, o_kind);
                compare_field("telescope_tag", oldest_record.telescope_tag, o_telescope_tag);
                compare_field("strip_id", oldest_record.strip_id, o_strip_id);
                compare_field("energy", oldest_record.energy, o_energy);
                compare_field("hit_time", oldest_record.hit_time, o_hit_time);
                compare_field("valid_res", oldest_record.valid_res, o_valid_res);
                compare_field("de_sum", oldest_record.de_sum, o_de_sum);
                compare_field("e_sum", oldest_record.e_sum, o_e_sum);
                compare_field("total_energy", oldest_record.total_energy, o_total_energy);
                compare_field("last", oldest_record.last, o_last);
                records_checked++;
            end
        end
    end

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------
    // Offers one item from a falling edge until a rising edge sees full low,
    // predicts it, then optionally idles. Push stays high between items
    // sent back to back.
    task automatic send_item(input t_cmd cmd, input logic [7:0] id,
                             input logic signed [23:0] q,
                             input logic signed [23:0] t);
        int gap;
        i_cmd = cmd;
        i_detector_id = id;
        i_charge = q;
        i_timing = t;
        push = 1'b1;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        predict_item(cmd, id, q, t);
        items_sent++;
        if (cmd == CMD_END) events_sent++;
        @(negedge i_clk);
        gap = sender_idle_en ? random_gap() : 0;
        if (gap > 0) begin
            push = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    // Waits until every predicted record has been transferred, then lets the
    // block finish any end marker that caused no record.
    task automatic wait_for_idle();
        push = 1'b0;
        while (expected_records.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_register(input logic [2:0] index, input logic [23:0] data);
        i_cfg_index = index;
        i_cfg_data = data;
        i_cfg_we = 1'b1;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        case (index)
            CFG_X_THRESHOLD:   cfg_x_thr = data;
            CFG_Y_THRESHOLD:   cfg_y_thr = data;
            CFG_DSSD_MODE:     cfg_dssd = data[0];
            CFG_E_DET_COUNT:   cfg_e_count = data[3:0];
            CFG_TELESCOPE_NUM: cfg_tel = data[7:0];
            default: ;
        endcase
    endtask

    task automatic apply_settings(input logic signed [23:0] x_thr,
                                  input logic signed [23:0] y_thr,
                                  input logic dssd, input logic [3:0] det_count,
                                  input logic [7:0] tel);
        wait_for_idle();
        write_register(CFG_X_THRESHOLD, x_thr);
        write_register(CFG_Y_THRESHOLD, y_thr);
        write_register(CFG_DSSD_MODE, {23'd0, dssd});
        write_register(CFG_E_DET_COUNT, {20'd0, det_count});
        write_register(CFG_TELESCOPE_NUM, {16'd0, tel});
        settings_applied++;
    endtask

    // Charges cluster where decisions are made: the cap, the layer threshold,
    // the ordinary physics range, and the extremes of the field.
    function automatic logic signed [23:0] pick_charge(input t_cmd cmd);
        logic signed [23:0] thr;
        int                 d;
        int                 v;
        thr = (cmd == CMD_Y) ? cfg_y_thr : ((cmd == CMD_X) ? cfg_x_thr : 24'sd0);
        d = $urandom_range(0, 4);
        v = $urandom_range(1, 3276800);
        case ($urandom_range(0, 9))
            0:          return ($urandom_range(0, 1) != 0) ? 24'sh7FFFFF : 24'sh800000;
            1:          return CHARGE_CAP + 24'(d - 2);
            2:          return thr + 24'(d - 2);
            3, 4, 5, 6: return 24'($urandom_range(0, 3276799));
            7:          return 24'(-v);
            default:    return 24'($urandom);
        endcase
    endfunction

    // One well-formed event: a mix of X, Y and E hits closed by an end marker.
    task automatic send_random_event(input int hit_count);
        t_cmd       cmd;
        int         r;
        logic [7:0] id;
        for (int h = 0; h < hit_count; h++) begin
            r = $urandom_range(0, 9);
            cmd = (r < 3) ? CMD_X : ((r < 6) ? CMD_Y : CMD_E);
            if (cmd == CMD_E && $urandom_range(0, 3) != 0)
                id = 8'($urandom_range(0, MAX_E));
            else
                id = 8'($urandom_range(0, 255));
            send_item(cmd, id, pick_charge(cmd), 24'($urandom));
        end
        send_item(CMD_END, 8'($urandom), 24'($urandom), 24'($urandom));
    endtask

    // Mostly ordinary events, with the odd empty one and the odd crowded one
    // that tends to overflow the E hit limit.
    task automatic run_random_events(input int item_target);
        int sent;
        int r;
        int hits;
        sent = 0;
        while (sent < item_target) begin
            r = $urandom_range(0, 19);
            if (r == 0)
                hits = 0;
            else if (r == 1)
                hits = $urandom_range(10, 14);
            else
                hits = $urandom_range(1, 8);
            send_random_event(hits);
            sent += hits + 1;
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Runs on the reset settings: thresholds zero, all eight E detectors.
    task automatic test_directed_cases();
        // Cap handling, ties, field extremes, repeated and out-of-range E ids.
        send_item(CMD_X, 8'd255, CHARGE_CAP, 24'sd5);
        send_item(CMD_X, 8'd1, CHARGE_CAP - 24'sd1, 24'sh7FFFFF);
        send_item(CMD_X, 8'd2, CHARGE_CAP - 24'sd1, 24'sd7);
        send_item(CMD_Y, 8'd0, 24'sh800000, 24'sh800000);
        send_item(CMD_Y, 8'd3, 24'sd0, 24'sd9);
        send_item(CMD_E, 8'd0, 24'sh7FFFFF, 24'sh7FFFFF);
        send_item(CMD_E, 8'd0, -24'sd1, 24'sd11);
        send_item(CMD_E, 8'd7, 24'sh800000, 24'sh800000);
        send_item(CMD_E, 8'd200, 24'sd12345, 24'sd13);
        send_item(CMD_END, 8'd0, 24'sd0, 24'sd0);
        // An end marker right after another one closes an empty event.
        send_item(CMD_END, 8'hFF, 24'shFFFFFF, 24'shFFFFFF);
        // X only at the cap, so no X is reported; Y passes alone.
        send_item(CMD_X, 8'd4, CHARGE_CAP, 24'sd1);
        send_item(CMD_Y, 8'd9, 24'sd100, 24'sd2);
        send_item(CMD_END, 8'd0, 24'sd0, 24'sd0);
        // Nine E hits against a limit of eight give a single error record.
        for (int i = 0; i <= MAX_E; i++)
            send_item(CMD_E, 8'(i), 24'(i * 1000), 24'(i));
        send_item(CMD_END, 8'd0, 24'sd0, 24'sd0);
        wait_for_idle();
    endtask

    task automatic test_default_settings();
        apply_settings(24'sd0, 24'sd0, 1'b0, E_DET_COUNT_RESET, 8'd0);
        run_random_events(60);
    endtask

    // Lowest and highest thresholds, both modes, no E detectors and one.
    task automatic test_threshold_extremes();
        apply_settings(24'sh800000, 24'sh7FFFFF, 1'b1, 4'd0, 8'd255);
        run_random_events(50);
        apply_settings(24'sh7FFFFF, 24'sh800000, 1'b0, 4'd1, 8'd0);
        run_random_events(50);
    endtask

    task automatic test_random_settings();
        for (int p = 0; p < 2; p++) begin
            apply_settings(24'($urandom_range(0, 3276800)), 24'($urandom),
                           1'($urandom), 4'($urandom_range(0, MAX_E)), 8'($urandom));
            run_random_events(45);
        end
    endtask

    // Both sides run flat out, so items and records move every cycle unless the block is full or has no record.
    task automatic test_no_idling();
        sender_idle_en = 1'b0;
        receiver_idle_en = 1'b0;
        apply_settings(24'($urandom_range(0, 1000000)), 24'($urandom_range(0, 1000000)),
                       1'b1, 4'($urandom_range(2, MAX_E)), 8'($urandom));
        run_random_events(50);
        wait_for_idle();
        sender_idle_en = 1'b1;
        receiver_idle_en = 1'b1;
    endtask

    // The receiver stops for a long stretch while events keep coming, so the
    // emission stalls, the item queue fills and full holds the sender.
    task automatic test_back_pressure();
        apply_settings(24'sd0, 24'sd0, 1'b0, 4'(MAX_E), 8'($urandom));
        sender_idle_en = 1'b0;
        consumer_hold = 200;
        for (int ev = 0; ev < 5; ev++)
            send_random_event(5);
        wait_for_idle();
        sender_idle_en = 1'b1;
    endtask

    // Arbitrary commands and fields with no event structure at all.
    task automatic test_noise();
        apply_settings(24'($urandom), 24'($urandom), 1'($urandom),
                       4'($urandom_range(0, MAX_E)), 8'($urandom));
        for (int n = 0; n < 40; n++)
            send_item(t_cmd'($urandom_range(0, 3)), 8'($urandom), 24'($urandom),
                      24'($urandom));
        send_item(CMD_END, 8'($urandom), 24'($urandom), 24'($urandom));
        wait_for_idle();
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        push = 1'b0;
        i_cmd = CMD_X;
        i_detector_id = '0;
        i_charge = '0;
        i_timing = '0;
        cfg_x_thr = '0;
        cfg_y_thr = '0;
        cfg_dssd = 1'b0;
        cfg_e_count = E_DET_COUNT_RESET;
        cfg_tel = '0;
        clear_event_state();

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed_cases();
        test_default_settings();
        test_threshold_extremes();
        test_random_settings();
        test_back_pressure();
        test_no_idling();
        test_noise();
        wait_for_idle();

        $display("Sent %0d items in %0d events under %0d register settings.",
                 items_sent, events_sent, settings_applied);
        $display("Checked %0d records, %0d mismatches found.", records_checked, error_count);
        if (error_count == 0) begin
            $display("PASS telescope_hit_selector_top");
        end else begin
            $display("FAIL telescope_hit_selector_top");
        end
        $finish;
    end

endmodule
